FILE: src/mvc_pkg.sv
// Shared types and constants of the MIDI volume and mute controller.
package mvc_pkg;

	typedef enum logic [1:0] {
		MODE_MIDI   = 2'd0,
		MODE_CONN   = 2'd1,
		MODE_AUDIO  = 2'd2,
		MODE_REINIT = 2'd3
	} mode_t;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_MIDI_CHANNEL  = 3'd0;
	localparam logic [2:0] REG_VOLUME_IN_CC  = 3'd1;
	localparam logic [2:0] REG_BUTTON_IN_CC  = 3'd2;
	localparam logic [2:0] REG_MUTE_OUT_CC   = 3'd3;
	localparam logic [2:0] REG_VOLUME_OUT_CC = 3'd4;
	localparam logic [2:0] REG_INIT_VOLUME   = 3'd5;
	localparam logic [2:0] REG_INIT_MUTE     = 3'd6;
	localparam logic [2:0] REG_GAIN_STEP     = 3'd7;

	localparam int unsigned ADDR_WIDTH = 5;

	localparam logic [3:0] CC_STATUS_NIBBLE = 4'hB;
	localparam logic [3:0] MIDI_MSG_LENGTH  = 4'd3;
	localparam logic [7:0] MIDI_DATA_MAX    = 8'd127;
	localparam logic [6:0] ENCODER_CENTER   = 7'd64;
	localparam logic [6:0] MIDI_VALUE_MAX   = 7'd127;

	localparam logic [3:0]  RST_MIDI_CHANNEL  = 4'd0;
	localparam logic [6:0]  RST_VOLUME_IN_CC  = 7'd114;
	localparam logic [6:0]  RST_BUTTON_IN_CC  = 7'd115;
	localparam logic [6:0]  RST_MUTE_OUT_CC   = 7'd118;
	localparam logic [6:0]  RST_VOLUME_OUT_CC = 7'd119;
	localparam logic [6:0]  RST_INIT_VOLUME   = 7'd0;
	localparam logic        RST_INIT_MUTE     = 1'b0;
	localparam logic [15:0] RST_GAIN_STEP     = 16'd64;

endpackage

FILE: src/mvc_in_if.sv
// Input channel: one event beat with its mode and payload fields.
interface mvc_in_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	mvc_pkg::mode_t                 mode;
	logic [3:0]                     msg_length;
	logic [7:0]                     msg_byte0;
	logic [7:0]                     msg_byte1;
	logic [7:0]                     msg_byte2;
	logic [7:0]                     conn_count;
	logic signed [SAMPLE_WIDTH-1:0] in_left;
	logic signed [SAMPLE_WIDTH-1:0] in_right;

	modport source (
		output valid, mode, msg_length, msg_byte0, msg_byte1, msg_byte2,
		       conn_count, in_left, in_right,
		input  ready
	);
	modport sink (
		input  valid, mode, msg_length, msg_byte0, msg_byte1, msg_byte2,
		       conn_count, in_left, in_right,
		output ready
	);
endinterface

FILE: src/mvc_out_if.sv
// Output channel: one result beat per accepted event.
interface mvc_out_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic                           status;
	logic                           handled;
	logic                           send_valid;
	logic [7:0]                     send_status_byte;
	logic [6:0]                     send_controller;
	logic [6:0]                     send_value;
	logic signed [SAMPLE_WIDTH-1:0] out_left;
	logic signed [SAMPLE_WIDTH-1:0] out_right;
	logic [6:0]                     cur_volume;
	logic                           cur_mute;
	logic [31:0]                    change_count;

	modport source (
		output valid, status, handled, send_valid, send_status_byte, send_controller,
		       send_value, out_left, out_right, cur_volume, cur_mute, change_count,
		input  ready
	);
	modport sink (
		input  valid, status, handled, send_valid, send_status_byte, send_controller,
		       send_value, out_left, out_right, cur_volume, cur_mute, change_count,
		output ready
	);
endinterface

FILE: src/midi_encoder_volume_mute_control.sv
// Top level of the MIDI encoder volume and mute controller.
// The block takes one event beat per clock while the output is not stalled and returns one
// result beat per event; each event passes the stage 1, stage 2 and output registers before
// its result is offered. Events are registered first; the controller state (volume, mute,
// button, connection count, gain ramp, generation) is updated combinationally between that
// register and the next stage, so consecutive events see each other's effects without stalls.
// The two sample multipliers sit in a stage of their own after the updated gain is registered.
// Each stage holds its beat only while the stage after it is full and stalled, so bubbles
// close up and intake stops only once all three stages hold beats behind a stalled result.
// Configuration registers are written through the APB port and must only change while idle.
module midi_encoder_volume_mute_control #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int GAIN_FRAC_BITS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mvc_pkg::ADDR_WIDTH-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	mvc_in_if.sink                          item_in,
	mvc_out_if.source                       result_out
);

	localparam int GW = GAIN_FRAC_BITS + 1;
	localparam int AW = ((GW > 16) ? GW : 16) + 1;
	localparam int PW = SAMPLE_WIDTH + GW + 1;
	localparam logic [GW-1:0] UNITY_GAIN = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

	// Configuration registers.
	logic [3:0]  midi_channel_q;
	logic [6:0]  volume_in_cc_q;
	logic [6:0]  button_in_cc_q;
	logic [6:0]  mute_out_cc_q;
	logic [6:0]  volume_out_cc_q;
	logic [6:0]  init_volume_q;
	logic        init_mute_q;
	logic [15:0] gain_step_q;

	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midi_channel_q  <= mvc_pkg::RST_MIDI_CHANNEL;
			volume_in_cc_q  <= mvc_pkg::RST_VOLUME_IN_CC;
			button_in_cc_q  <= mvc_pkg::RST_BUTTON_IN_CC;
			mute_out_cc_q   <= mvc_pkg::RST_MUTE_OUT_CC;
			volume_out_cc_q <= mvc_pkg::RST_VOLUME_OUT_CC;
			init_volume_q   <= mvc_pkg::RST_INIT_VOLUME;
			init_mute_q     <= mvc_pkg::RST_INIT_MUTE;
			gain_step_q     <= mvc_pkg::RST_GAIN_STEP;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				mvc_pkg::REG_MIDI_CHANNEL:  midi_channel_q  <= pwdata[3:0];
				mvc_pkg::REG_VOLUME_IN_CC:  volume_in_cc_q  <= pwdata[6:0];
				mvc_pkg::REG_BUTTON_IN_CC:  button_in_cc_q  <= pwdata[6:0];
				mvc_pkg::REG_MUTE_OUT_CC:   mute_out_cc_q   <= pwdata[6:0];
				mvc_pkg::REG_VOLUME_OUT_CC: volume_out_cc_q <= pwdata[6:0];
				mvc_pkg::REG_INIT_VOLUME:   init_volume_q   <= pwdata[6:0];
				mvc_pkg::REG_INIT_MUTE:     init_mute_q     <= pwdata[0];
				mvc_pkg::REG_GAIN_STEP:     gain_step_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			mvc_pkg::REG_MIDI_CHANNEL:  prdata = {28'd0, midi_channel_q};
			mvc_pkg::REG_VOLUME_IN_CC:  prdata = {25'd0, volume_in_cc_q};
			mvc_pkg::REG_BUTTON_IN_CC:  prdata = {25'd0, button_in_cc_q};
			mvc_pkg::REG_MUTE_OUT_CC:   prdata = {25'd0, mute_out_cc_q};
			mvc_pkg::REG_VOLUME_OUT_CC: prdata = {25'd0, volume_out_cc_q};
			mvc_pkg::REG_INIT_VOLUME:   prdata = {25'd0, init_volume_q};
			mvc_pkg::REG_INIT_MUTE:     prdata = {31'd0, init_mute_q};
			mvc_pkg::REG_GAIN_STEP:     prdata = {16'd0, gain_step_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// Stage enables: a stage loads when it is empty or its beat moves on.
	logic valid_s1, valid_s2, valid_s3;
	logic en1, en2, en3;
	assign en3 = !valid_s3 || result_out.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign item_in.ready = en1;

	// Stage 1: registered event.
	mvc_pkg::mode_t                 mode_s1;
	logic [3:0]                     msg_length_s1;
	logic [7:0]                     msg_byte0_s1, msg_byte1_s1, msg_byte2_s1;
	logic [7:0]                     conn_count_s1;
	logic signed [SAMPLE_WIDTH-1:0] left_s1, right_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && item_in.valid) begin
			mode_s1       <= item_in.mode;
			msg_length_s1 <= item_in.msg_length;
			msg_byte0_s1  <= item_in.msg_byte0;
			msg_byte1_s1  <= item_in.msg_byte1;
			msg_byte2_s1  <= item_in.msg_byte2;
			conn_count_s1 <= item_in.conn_count;
			left_s1       <= item_in.in_left;
			right_s1      <= item_in.in_right;
		end
	end

	// Controller state.
	logic [6:0]    volume_q;
	logic          muted_q;
	logic          button_held_q;
	logic [7:0]    last_conn_q;
	logic          conn_known_q;
	logic [GW-1:0] gain_q;
	logic [31:0]   generation_q;

	logic [6:0]    volume_d;
	logic          muted_d;
	logic          button_held_d;
	logic [7:0]    last_conn_d;
	logic          conn_known_d;
	logic [GW-1:0] gain_d;
	logic [31:0]   generation_d;
	logic          status_d, handled_d, send_d;
	logic [6:0]    ctl_d, val_d;

	logic          cc_match;
	logic signed [8:0] vol_next;
	logic          pressed;
	logic [AW-1:0] gain_ext, target_ext, step_ext, gain_up, gain_gap;
	logic [GW-1:0] target;

	assign cc_match = (msg_length_s1 == mvc_pkg::MIDI_MSG_LENGTH)
		&& (msg_byte0_s1[7:4] == mvc_pkg::CC_STATUS_NIBBLE)
		&& (msg_byte0_s1[3:0] == midi_channel_q);
	assign vol_next = $signed({2'b00, volume_q}) + $signed({2'b00, msg_byte2_s1[6:0]})
		- $signed({2'b00, mvc_pkg::ENCODER_CENTER});
	assign pressed = (msg_byte2_s1[6:0] >= mvc_pkg::ENCODER_CENTER);

	assign target     = muted_q ? '0 : UNITY_GAIN;
	assign gain_ext   = AW'(gain_q);
	assign target_ext = AW'(target);
	assign step_ext   = AW'(gain_step_q);
	assign gain_up    = gain_ext + step_ext;
	assign gain_gap   = gain_ext - target_ext;

	always_comb begin
		volume_d      = volume_q;
		muted_d       = muted_q;
		button_held_d = button_held_q;
		last_conn_d   = last_conn_q;
		conn_known_d  = conn_known_q;
		gain_d        = gain_q;
		generation_d  = generation_q;
		status_d      = 1'b0;
		handled_d     = 1'b0;
		send_d        = 1'b0;
		ctl_d         = '0;
		val_d         = '0;
		case (mode_s1)
			mvc_pkg::MODE_MIDI: begin
				if (cc_match) begin
					if (msg_byte1_s1 > mvc_pkg::MIDI_DATA_MAX
						|| msg_byte2_s1 > mvc_pkg::MIDI_DATA_MAX) begin
						status_d = 1'b1;
					end else if (msg_byte1_s1[6:0] == volume_in_cc_q) begin
						handled_d = 1'b1;
						if (msg_byte2_s1[6:0] != mvc_pkg::ENCODER_CENTER) begin
							if (vol_next < 0) begin
								volume_d = '0;
							end else if (vol_next > $signed({2'b00, mvc_pkg::MIDI_VALUE_MAX})) begin
								volume_d = mvc_pkg::MIDI_VALUE_MAX;
							end else begin
								volume_d = vol_next[6:0];
							end
							generation_d = generation_q + 32'd1;
							send_d       = 1'b1;
							ctl_d        = volume_out_cc_q;
							val_d        = volume_d;
						end
					end else if (msg_byte1_s1[6:0] == button_in_cc_q) begin
						handled_d     = 1'b1;
						button_held_d = pressed;
						if (pressed && !button_held_q) begin
							muted_d      = !muted_q;
							generation_d = generation_q + 32'd1;
							send_d       = 1'b1;
							ctl_d        = mute_out_cc_q;
							val_d        = {7{muted_d}};
						end
					end
				end
			end
			mvc_pkg::MODE_CONN: begin
				if (conn_count_s1 != 8'd0
					&& (!conn_known_q || conn_count_s1 > last_conn_q)) begin
					send_d = 1'b1;
					ctl_d  = volume_out_cc_q;
					val_d  = volume_q;
				end
				last_conn_d  = conn_count_s1;
				conn_known_d = 1'b1;
			end
			mvc_pkg::MODE_AUDIO: begin
				// The gain moves one step toward the mute target and stops on it.
				if (gain_ext < target_ext) begin
					gain_d = (gain_up > target_ext) ? target : gain_up[GW-1:0];
				end else if (gain_ext > target_ext) begin
					gain_d = (gain_gap < step_ext) ? target : GW'(gain_ext - step_ext);
				end
			end
			mvc_pkg::MODE_REINIT: begin
				volume_d      = init_volume_q;
				muted_d       = init_mute_q;
				button_held_d = 1'b0;
				last_conn_d   = '0;
				conn_known_d  = 1'b0;
				gain_d        = init_mute_q ? '0 : UNITY_GAIN;
				generation_d  = '0;
			end
			default: ;
		endcase
	end

	logic advance_s1;
	assign advance_s1 = valid_s1 && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q      <= '0;
			muted_q       <= 1'b0;
			button_held_q <= 1'b0;
			last_conn_q   <= '0;
			conn_known_q  <= 1'b0;
			gain_q        <= UNITY_GAIN;
			generation_q  <= '0;
		end else if (advance_s1) begin
			volume_q      <= volume_d;
			muted_q       <= muted_d;
			button_held_q <= button_held_d;
			last_conn_q   <= last_conn_d;
			conn_known_q  <= conn_known_d;
			gain_q        <= gain_d;
			generation_q  <= generation_d;
		end
	end

	// Stage 2: event results plus the gain and samples for scaling.
	logic                           status_s2, handled_s2, send_s2, audio_s2;
	logic [6:0]                     ctl_s2, val_s2, volume_s2;
	logic                           muted_s2;
	logic [31:0]                    generation_s2;
	logic [GW-1:0]                  gain_s2;
	logic signed [SAMPLE_WIDTH-1:0] left_s2, right_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			status_s2     <= status_d;
			handled_s2    <= handled_d;
			send_s2       <= send_d;
			ctl_s2        <= ctl_d;
			val_s2        <= val_d;
			volume_s2     <= volume_d;
			muted_s2      <= muted_d;
			generation_s2 <= generation_d;
			gain_s2       <= gain_d;
			audio_s2      <= (mode_s1 == mvc_pkg::MODE_AUDIO);
			left_s2       <= left_s1;
			right_s2      <= right_s1;
		end
	end

	// Scaling: the arithmetic shift drops the low bits, rounding toward minus infinity.
	logic signed [PW-1:0] prod_left, prod_right;
	assign prod_left  = PW'(left_s2) * $signed({1'b0, gain_s2});
	assign prod_right = PW'(right_s2) * $signed({1'b0, gain_s2});

	// Stage 3: output register.
	logic                           status_s3, handled_s3, send_s3;
	logic [6:0]                     ctl_s3, val_s3, volume_s3;
	logic                           muted_s3;
	logic [31:0]                    generation_s3;
	logic signed [SAMPLE_WIDTH-1:0] left_s3, right_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			status_s3     <= status_s2;
			handled_s3    <= handled_s2;
			send_s3       <= send_s2;
			ctl_s3        <= ctl_s2;
			val_s3        <= val_s2;
			volume_s3     <= volume_s2;
			muted_s3      <= muted_s2;
			generation_s3 <= generation_s2;
			left_s3       <= audio_s2
				? prod_left[GAIN_FRAC_BITS +: SAMPLE_WIDTH] : '0;
			right_s3      <= audio_s2
				? prod_right[GAIN_FRAC_BITS +: SAMPLE_WIDTH] : '0;
		end
	end

	assign result_out.valid            = valid_s3;
	assign result_out.status           = status_s3;
	assign result_out.handled          = handled_s3;
	assign result_out.send_valid       = send_s3;
	assign result_out.send_status_byte = send_s3 ? {mvc_pkg::CC_STATUS_NIBBLE, midi_channel_q}
		: 8'd0;
	assign result_out.send_controller  = ctl_s3;
	assign result_out.send_value       = val_s3;
	assign result_out.out_left         = left_s3;
	assign result_out.out_right        = right_s3;
	assign result_out.cur_volume       = volume_s3;
	assign result_out.cur_mute         = muted_s3;
	assign result_out.change_count     = generation_s3;

endmodule

FILE: src/mvc_checker.sv
// Port-level checker for the volume and mute controller, bound to the top level.
module mvc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       status,
	input logic       handled,
	input logic       send_valid,
	input logic [7:0] send_status_byte,
	input logic [6:0] send_controller,
	input logic [6:0] send_value
);

	// A result beat that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// Without an emitted message the message fields read as zero.
	a_send_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_valid |-> send_status_byte == 8'd0 && send_controller == 7'd0
			&& send_value == 7'd0)
		else $error("message fields set without an emitted message");

	// A rejected data byte neither counts as handled nor emits anything.
	a_status_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !handled && !send_valid)
		else $error("invalid data byte acted on");

	// Emitted messages are always control changes.
	a_send_cc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_valid |-> send_status_byte[7:4] == mvc_pkg::CC_STATUS_NIBBLE)
		else $error("emitted message is not a control change");

endmodule

bind midi_encoder_volume_mute_control mvc_checker u_mvc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (result_out.valid),
	.out_ready        (result_out.ready),
	.status           (result_out.status),
	.handled          (result_out.handled),
	.send_valid       (result_out.send_valid),
	.send_status_byte (result_out.send_status_byte),
	.send_controller  (result_out.send_controller),
	.send_value       (result_out.send_value)
);

FILE: tb/sv/midi_encoder_volume_mute_control_tb.sv
// Self-checking testbench of the MIDI volume and mute controller with its own prediction.
module midi_encoder_volume_mute_control_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 24;
	localparam int FRAC = 15;
	localparam int unsigned UNITY_GAIN = 32'd1 << FRAC;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 6;

	localparam logic [7:0] CC_CH0      = {mvc_pkg::CC_STATUS_NIBBLE, 4'd0};
	localparam logic [7:0] CC_CH1      = {mvc_pkg::CC_STATUS_NIBBLE, 4'd1};
	localparam logic [7:0] NOTE_ON_CH0 = 8'h90;
	localparam logic [7:0] VOL_CC      = {1'b0, mvc_pkg::RST_VOLUME_IN_CC};
	localparam logic [7:0] BTN_CC      = {1'b0, mvc_pkg::RST_BUTTON_IN_CC};
	localparam logic [7:0] OTHER_CC    = 8'd7;
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

	typedef struct {
		mvc_pkg::mode_t        mode;
		logic [3:0]            msg_length;
		logic [7:0]            b0;
		logic [7:0]            b1;
		logic [7:0]            b2;
		logic [7:0]            conn;
		logic signed [SW-1:0]  left;
		logic signed [SW-1:0]  right;
	} ctl_event_t;

	typedef struct {
		logic                  status;
		logic                  handled;
		logic                  send_valid;
		logic [7:0]            send_status_byte;
		logic [6:0]            send_controller;
		logic [6:0]            send_value;
		logic signed [SW-1:0]  out_left;
		logic signed [SW-1:0]  out_right;
		logic [6:0]            cur_volume;
		logic                  cur_mute;
		logic [31:0]           change_count;
	} ctl_outcome_t;

	typedef struct {
		logic [3:0]  channel;
		logic [6:0]  volume_in_cc;
		logic [6:0]  button_in_cc;
		logic [6:0]  mute_out_cc;
		logic [6:0]  volume_out_cc;
		logic [6:0]  init_volume;
		logic        init_mute;
		logic [15:0] gain_step;
	} ctl_settings_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [mvc_pkg::ADDR_WIDTH-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	mvc_in_if #(.SAMPLE_WIDTH(SW)) item_if();
	mvc_out_if #(.SAMPLE_WIDTH(SW)) result_if();

	midi_encoder_volume_mute_control #(
		.SAMPLE_WIDTH  (SW),
		.GAIN_FRAC_BITS(FRAC)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.item_in   (item_if),
		.result_out(result_if)
	);

	// Predicted controller state and the register copy it works with.
	ctl_settings_t settings;
	logic [6:0]    volume;
	logic          muted;
	logic          button_held;
	logic [7:0]    last_conn;
	logic          conn_known;
	int unsigned   gain;
	logic [31:0]   generation;

	ctl_outcome_t pending_outcomes[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int stall_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("midi_encoder_volume_mute_control regression: fail");
			$finish;
		end
	end

	function automatic int draw_pause(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	function automatic void reload_state();
		volume = settings.init_volume;
		muted = settings.init_mute;
		button_held = 1'b0;
		last_conn = '0;
		conn_known = 1'b0;
		gain = settings.init_mute ? 0 : UNITY_GAIN;
		generation = '0;
	endfunction

	// Sample times gain, dropping the fraction bits (rounds toward minus infinity).
	function automatic logic signed [SW-1:0] scale_sample(logic signed [SW-1:0] s);
		longint p;
		p = longint'(s) * longint'(gain);
		p = p >>> FRAC;
		return p[SW-1:0];
	endfunction

	function automatic ctl_outcome_t apply_event(ctl_event_t ev);
		ctl_outcome_t r;
		int next_vol;
		int unsigned target;
		logic [6:0] ctl;
		logic [6:0] val;
		logic pressed;
		r = '{default: '0};
		ctl = '0;
		val = '0;
		case (ev.mode)
			mvc_pkg::MODE_MIDI: begin
				if (ev.msg_length == mvc_pkg::MIDI_MSG_LENGTH
						&& ev.b0[7:4] == mvc_pkg::CC_STATUS_NIBBLE
						&& ev.b0[3:0] == settings.channel) begin
					if (ev.b1 > mvc_pkg::MIDI_DATA_MAX || ev.b2 > mvc_pkg::MIDI_DATA_MAX) begin
						r.status = 1'b1;
					end else if (ev.b1[6:0] == settings.volume_in_cc) begin
						r.handled = 1'b1;
						if (ev.b2[6:0] != mvc_pkg::ENCODER_CENTER) begin
							next_vol = int'(volume) + int'(ev.b2)
								- int'(mvc_pkg::ENCODER_CENTER);
							if (next_vol < 0)
								next_vol = 0;
							if (next_vol > int'(mvc_pkg::MIDI_VALUE_MAX))
								next_vol = int'(mvc_pkg::MIDI_VALUE_MAX);
							volume = next_vol[6:0];
							generation++;
							r.send_valid = 1'b1;
							ctl = settings.volume_out_cc;
							val = volume;
						end
					end else if (ev.b1[6:0] == settings.button_in_cc) begin
						r.handled = 1'b1;
						pressed = ev.b2 >= 8'(mvc_pkg::ENCODER_CENTER);
						if (pressed && !button_held) begin
							muted = !muted;
							generation++;
							r.send_valid = 1'b1;
							ctl = settings.mute_out_cc;
							val = muted ? mvc_pkg::MIDI_VALUE_MAX : 7'd0;
						end
						button_held = pressed;
					end
				end
			end
			mvc_pkg::MODE_CONN: begin
				if (ev.conn != 0 && (!conn_known || ev.conn > last_conn)) begin
					r.send_valid = 1'b1;
					ctl = settings.volume_out_cc;
					val = volume;
				end
				last_conn = ev.conn;
				conn_known = 1'b1;
			end
			mvc_pkg::MODE_AUDIO: begin
				target = muted ? 0 : UNITY_GAIN;
				if (gain < target)
					gain = (gain + settings.gain_step > target) ? target : gain + settings.gain_step;
				else if (gain > target)
					gain = (gain - target < settings.gain_step) ? target : gain - settings.gain_step;
				r.out_left = scale_sample(ev.left);
				r.out_right = scale_sample(ev.right);
			end
			default: begin
				reload_state();
			end
		endcase
		if (r.send_valid) begin
			r.send_status_byte = {mvc_pkg::CC_STATUS_NIBBLE, settings.channel};
			r.send_controller = ctl;
			r.send_value = val;
		end
		r.cur_volume = volume;
		r.cur_mute = muted;
		r.change_count = generation;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		ctl_outcome_t w;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result beat arrived with no event outstanding");
				mismatch_count++;
			end else begin
				w = pending_outcomes.pop_front();
				check_field("status", 32'(w.status), 32'(result_if.status));
				check_field("handled", 32'(w.handled), 32'(result_if.handled));
				check_field("send_valid", 32'(w.send_valid), 32'(result_if.send_valid));
				check_field("send_status_byte", 32'(w.send_status_byte),
					32'(result_if.send_status_byte));
				check_field("send_controller", 32'(w.send_controller),
					32'(result_if.send_controller));
				check_field("send_value", 32'(w.send_value), 32'(result_if.send_value));
				check_field("out_left", 32'(w.out_left), 32'(result_if.out_left));
				check_field("out_right", 32'(w.out_right), 32'(result_if.out_right));
				check_field("cur_volume", 32'(w.cur_volume), 32'(result_if.cur_volume));
				check_field("cur_mute", 32'(w.cur_mute), 32'(result_if.cur_mute));
				check_field("change_count", w.change_count, result_if.change_count);
			end
		end
	end

	// Result-side back-pressure.
	always @(negedge clk) begin
		if (stall_left == 0)
			stall_left = draw_pause(snk_idle_pct);
		result_if.ready = (stall_left == 0);
		if (stall_left > 0)
			stall_left--;
	end

	task automatic send_event(ctl_event_t ev);
		int gap;
		gap = draw_pause(src_idle_pct);
		@(negedge clk);
		if (gap > 0) begin
			item_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_if.mode = ev.mode;
		item_if.msg_length = ev.msg_length;
		item_if.msg_byte0 = ev.b0;
		item_if.msg_byte1 = ev.b1;
		item_if.msg_byte2 = ev.b2;
		item_if.conn_count = ev.conn;
		item_if.in_left = ev.left;
		item_if.in_right = ev.right;
		item_if.valid = 1'b1;
		do @(posedge clk); while (!item_if.ready);
		pending_outcomes.push_back(apply_event(ev));
	endtask

	task automatic send_fields(mvc_pkg::mode_t m, logic [3:0] len, logic [7:0] b0,
			logic [7:0] b1, logic [7:0] b2, logic [7:0] conn, logic signed [SW-1:0] l,
			logic signed [SW-1:0] r);
		ctl_event_t ev;
		ev = '{m, len, b0, b1, b2, conn, l, r};
		send_event(ev);
	endtask

	// Mostly well-formed controller traffic for the current settings, some broken, some noise.
	function automatic ctl_event_t random_event(int audio_pct);
		ctl_event_t ev;
		int pick;
		ev.mode = mvc_pkg::mode_t'($urandom_range(0, 3));
		ev.msg_length = 4'($urandom);
		ev.b0 = 8'($urandom);
		ev.b1 = 8'($urandom);
		ev.b2 = 8'($urandom);
		ev.conn = 8'($urandom);
		ev.left = SW'($urandom);
		ev.right = SW'($urandom);
		pick = ($urandom_range(0, 99) < audio_pct) ? 70 : $urandom_range(0, 99);
		if (pick < 58) begin
			ev.mode = mvc_pkg::MODE_MIDI;
			ev.msg_length = mvc_pkg::MIDI_MSG_LENGTH;
			ev.b0 = {mvc_pkg::CC_STATUS_NIBBLE, settings.channel};
			if (pick < 42) begin
				ev.b1 = {1'b0, settings.volume_in_cc};
				ev.b2 = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
					: 8'($urandom_range(56, 72));
			end else begin
				ev.b1 = {1'b0, settings.button_in_cc};
				ev.b2 = $urandom_range(0, 1) ? 8'($urandom_range(64, 127))
					: 8'($urandom_range(0, 63));
			end
			case ($urandom_range(0, 29))
				0: ev.b2[7] = 1'b1;
				1: ev.b1[7] = 1'b1;
				2: ev.msg_length = 4'($urandom);
				3: ev.b0[3:0] = 4'($urandom);
				default: ;
			endcase
		end else if (pick < 66) begin
			ev.mode = mvc_pkg::MODE_CONN;
			if ($urandom_range(0, 3) != 0)
				ev.conn = 8'($urandom_range(0, 6));
		end else if (pick < 89) begin
			ev.mode = mvc_pkg::MODE_AUDIO;
			if ($urandom_range(0, 7) == 0) begin
				ev.left = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
				ev.right = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			end
		end else if (pick < 91) begin
			ev.mode = mvc_pkg::MODE_REINIT;
		end
		return ev;
	endfunction

	task automatic send_reinit();
		ctl_event_t ev;
		ev = random_event(0);
		ev.mode = mvc_pkg::MODE_REINIT;
		send_event(ev);
	endtask

	task automatic run_random(int count, int audio_pct);
		repeat (count) send_event(random_event(audio_pct));
	endtask

	// Drop valid and wait until every result is back and the pipeline has drained.
	task automatic settle();
		@(negedge clk);
		item_if.valid = 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apply_settings(ctl_settings_t s);
		settle();
		write_reg(mvc_pkg::REG_MIDI_CHANNEL, 32'(s.channel));
		write_reg(mvc_pkg::REG_VOLUME_IN_CC, 32'(s.volume_in_cc));
		write_reg(mvc_pkg::REG_BUTTON_IN_CC, 32'(s.button_in_cc));
		write_reg(mvc_pkg::REG_MUTE_OUT_CC, 32'(s.mute_out_cc));
		write_reg(mvc_pkg::REG_VOLUME_OUT_CC, 32'(s.volume_out_cc));
		write_reg(mvc_pkg::REG_INIT_VOLUME, 32'(s.init_volume));
		write_reg(mvc_pkg::REG_INIT_MUTE, 32'(s.init_mute));
		write_reg(mvc_pkg::REG_GAIN_STEP, 32'(s.gain_step));
		settings = s;
	endtask

	function automatic ctl_settings_t random_settings();
		ctl_settings_t s;
		s.channel = 4'($urandom);
		s.volume_in_cc = 7'($urandom);
		s.button_in_cc = ($urandom_range(0, 7) == 0) ? s.volume_in_cc : 7'($urandom);
		s.mute_out_cc = 7'($urandom);
		s.volume_out_cc = 7'($urandom);
		s.init_volume = 7'($urandom);
		s.init_mute = 1'($urandom);
		case ($urandom_range(0, 3))
			0: s.gain_step = 16'($urandom_range(1, 63));
			1: s.gain_step = 16'($urandom_range(64, 1023));
			2: s.gain_step = 16'($urandom_range(1024, 32768));
			default: s.gain_step = 16'($urandom);
		endcase
		return s;
	endfunction

	task automatic test_directed_events();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		send_fields(mvc_pkg::MODE_AUDIO, '0, '0, '0, '0, '0, SAMPLE_MAX, SAMPLE_MIN);
		send_fields(mvc_pkg::MODE_AUDIO, '0, '0, '0, '0, '0, -24'sd1, 24'sd1);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, VOL_CC, 8'd127,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, VOL_CC, 8'd127,
			'0, '0, '0);
		// A step of one raises the volume to its maximum of 127.
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, VOL_CC, 8'd65,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, VOL_CC, 8'd64,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, VOL_CC, 8'd0,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, VOL_CC, 8'd200,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, VOL_CC | 8'h80,
			8'd1, '0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH1, VOL_CC, 8'd127,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, 4'd2, CC_CH0, VOL_CC, 8'd127, '0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, NOTE_ON_CH0, VOL_CC, 8'd127,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, OTHER_CC, 8'd127,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, BTN_CC, 8'd127,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, BTN_CC, 8'd100,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, BTN_CC, 8'd0,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_AUDIO, '0, '0, '0, '0, '0, SAMPLE_MIN, SAMPLE_MAX);
		send_fields(mvc_pkg::MODE_MIDI, mvc_pkg::MIDI_MSG_LENGTH, CC_CH0, BTN_CC, 8'd64,
			'0, '0, '0);
		send_fields(mvc_pkg::MODE_CONN, '0, '0, '0, '0, 8'd0, '0, '0);
		send_fields(mvc_pkg::MODE_CONN, '0, '0, '0, '0, 8'd3, '0, '0);
		send_fields(mvc_pkg::MODE_CONN, '0, '0, '0, '0, 8'd2, '0, '0);
		send_fields(mvc_pkg::MODE_CONN, '0, '0, '0, '0, 8'd255, '0, '0);
		send_fields(mvc_pkg::MODE_REINIT, '0, '0, '0, '0, '0, '0, '0);
		send_fields(mvc_pkg::MODE_CONN, '0, '0, '0, '0, 8'd1, '0, '0);
		send_fields(mvc_pkg::MODE_AUDIO, '0, '0, '0, '0, '0, SAMPLE_MAX, -24'sd1);
	endtask

	task automatic test_register_extremes();
		// Both inputs on one controller: the encoder takes precedence.
		apply_settings('{4'd15, 7'd0, 7'd0, 7'd127, 7'd127, 7'd127, 1'b1, 16'd32768});
		src_idle_pct = 30;
		snk_idle_pct = 30;
		send_reinit();
		run_random(150, 10);
		apply_settings('{4'd9, 7'd127, 7'd126, 7'd0, 7'd0, 7'd0, 1'b0, 16'd1});
		src_idle_pct = 0;
		snk_idle_pct = 60;
		send_reinit();
		run_random(150, 10);
	endtask

	task automatic test_ramp_limits();
		ctl_settings_t s;
		logic [15:0] steps[4];
		steps = '{16'd0, 16'hFFFF, 16'd4096, 16'd32768};
		foreach (steps[i]) begin
			s = random_settings();
			s.gain_step = steps[i];
			s.init_mute = i[0];
			apply_settings(s);
			src_idle_pct = (i == 1) ? 0 : 20;
			snk_idle_pct = (i == 2) ? 0 : 20;
			send_reinit();
			run_random(90, 60);
		end
	endtask

	task automatic test_random_settings();
		int pcts[4];
		pcts = '{0, 10, 30, 60};
		repeat (5) begin
			apply_settings(random_settings());
			src_idle_pct = pcts[$urandom_range(0, 3)];
			snk_idle_pct = pcts[$urandom_range(0, 3)];
			send_reinit();
			run_random(180, 15);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_if.valid = 1'b0;
		item_if.mode = mvc_pkg::MODE_MIDI;
		item_if.msg_length = '0;
		item_if.msg_byte0 = '0;
		item_if.msg_byte1 = '0;
		item_if.msg_byte2 = '0;
		item_if.conn_count = '0;
		item_if.in_left = '0;
		item_if.in_right = '0;
		settings = '{mvc_pkg::RST_MIDI_CHANNEL, mvc_pkg::RST_VOLUME_IN_CC,
			mvc_pkg::RST_BUTTON_IN_CC, mvc_pkg::RST_MUTE_OUT_CC, mvc_pkg::RST_VOLUME_OUT_CC,
			mvc_pkg::RST_INIT_VOLUME, mvc_pkg::RST_INIT_MUTE, mvc_pkg::RST_GAIN_STEP};
		reload_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_events();
		test_register_extremes();
		test_ramp_limits();
		test_random_settings();

		settle();
		if (mismatch_count == 0)
			$display("midi_encoder_volume_mute_control regression: pass");
		else
			$display("midi_encoder_volume_mute_control regression: fail");
		$finish;
	end

endmodule
